// ===== rtl/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern scan unit.
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int unsigned MaxPattern = 24;
  localparam int unsigned SigBytes   = 24;
  localparam int unsigned WinIdxW    = $clog2(MaxPattern);
  localparam int unsigned LenW       = 5;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgIdxW    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_LOW  = 3'd0,
    CFG_PAT_MID  = 3'd1,
    CFG_PAT_HIGH = 3'd2,
    CFG_CARE     = 3'd3,
    CFG_LEN      = 3'd4,
    CFG_BASE     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [SigBytes*8-1:0] sig;
    logic [SigBytes-1:0]   care;
    logic [LenW-1:0]       len;
    logic [AddrW-1:0]      base;
  } cfg_t;

  typedef struct packed {
    logic             emit;
    logic             found;
    logic [AddrW-1:0] match_address;
  } res_t;

endpackage

// ===== rtl/wbps_if.sv =====
// Valid/ready channel interfaces for scan input bytes and scan results.
`timescale 1ns / 1ps

interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [wbps_pkg::AddrW-1:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink   (input valid, input found, input match_address, output ready);
endinterface

// ===== rtl/wildcard_byte_pattern_scan_unit.sv =====
// Top level of the wildcard byte pattern scan unit.
`timescale 1ns / 1ps

// Scans a byte stream for a signature of up to 24 bytes with per-byte
// wildcards. Input channel in_i carries one byte per item plus a last_byte
// flag closing the region. Output channel out_o carries at most one item per
// region: found=1 with base address plus match offset at the first match, or
// found=0 with address zero when the region ends with no match.
// Configuration goes through cfg_we_i/cfg_idx_i/cfg_wdata_i, one register
// per write. It must be changed only while the block is idle; the block
// itself leaves this to the user. Each byte waits in the input register,
// is compared against the whole window in parallel, and its result lands
// in the output register as the byte advances out of the input register.
// One byte is taken every cycle as long as the output register is empty or
// being drained; the window compare is done in a single pass so nothing
// else limits the rate.
// A stalled receiver holds the result; the input register then fills and
// in_i.ready drops until the result is taken.
// Reset clears the valid flags, the configuration, the position count and
// the window fill.

module wildcard_byte_pattern_scan_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wbps_pkg::CfgDataW-1:0] cfg_wdata_i,
  wbps_in_if.sink                       in_i,
  wbps_out_if.source                    out_o
);

  wbps_pkg::cfg_t cfg;
  wbps_pkg::res_t res;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;

  logic                       out_vld_q;
  logic                       out_found_q;
  logic [wbps_pkg::AddrW-1:0] out_addr_q;

  wbps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  wbps_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res.emit;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) begin
      out_found_q <= res.found;
      out_addr_q  <= res.match_address;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.found         = out_found_q;
  assign out_o.match_address = out_addr_q;

endmodule

// ===== rtl/wbps_cfg_regs.sv =====
// Configuration register file: signature, care mask, length, base address.
`timescale 1ns / 1ps

module wbps_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [wbps_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output wbps_pkg::cfg_t                   cfg_o
);

  wbps_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (wbps_pkg::cfg_idx_e'(cfg_idx_i))
        wbps_pkg::CFG_PAT_LOW:  cfg_q.sig[63:0]    <= cfg_wdata_i;
        wbps_pkg::CFG_PAT_MID:  cfg_q.sig[127:64]  <= cfg_wdata_i;
        wbps_pkg::CFG_PAT_HIGH: cfg_q.sig[191:128] <= cfg_wdata_i;
        wbps_pkg::CFG_CARE:     cfg_q.care <= cfg_wdata_i[wbps_pkg::SigBytes-1:0];
        wbps_pkg::CFG_LEN:      cfg_q.len  <= cfg_wdata_i[wbps_pkg::LenW-1:0];
        wbps_pkg::CFG_BASE:     cfg_q.base <= cfg_wdata_i[wbps_pkg::AddrW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/wbps_match.sv =====
// Byte window, position/fill tracking and parallel wildcard compare.
`timescale 1ns / 1ps

module wbps_match (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  input  wbps_pkg::cfg_t cfg_i,
  output wbps_pkg::res_t res_o
);

  logic [7:0]                   win_q [wbps_pkg::MaxPattern];
  logic [7:0]                   win_nx [wbps_pkg::MaxPattern];
  logic [wbps_pkg::WinIdxW-1:0] fill_q, fill_d, fill_nx;
  logic [wbps_pkg::AddrW-1:0]   pos_q, pos_d, pos_nx;
  logic                         seen_q, seen_d;
  logic                         hit;
  logic                         len_ok;
  logic [wbps_pkg::LenW-1:0]    age;

  // window as it stands after the new byte shifts in; entry 0 is newest
  always_comb begin
    win_nx[0] = data_byte_i;
    for (int k = 1; k < wbps_pkg::MaxPattern; k++) begin
      win_nx[k] = win_q[k-1];
    end
  end

  assign fill_nx = (fill_q == wbps_pkg::WinIdxW'(wbps_pkg::MaxPattern)) ?
                   fill_q : fill_q + 1'b1;
  assign pos_nx  = pos_q + 1'b1;

  assign len_ok = (cfg_i.len != '0) &&
                  (cfg_i.len <= wbps_pkg::LenW'(wbps_pkg::SigBytes)) &&
                  (cfg_i.len <= wbps_pkg::LenW'(wbps_pkg::MaxPattern)) &&
                  (wbps_pkg::LenW'(fill_nx) >= cfg_i.len);

  // signature byte j lines up with the byte (len-1-j) positions back
  always_comb begin
    hit = len_ok;
    age = '0;
    for (int j = 0; j < wbps_pkg::SigBytes; j++) begin
      age = cfg_i.len - wbps_pkg::LenW'(j) - 1'b1;
      if ((wbps_pkg::LenW'(j) < cfg_i.len) && cfg_i.care[j]) begin
        if (win_nx[age[wbps_pkg::WinIdxW-1:0]] != cfg_i.sig[j*8 +: 8]) begin
          hit = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res_o.emit          = !seen_q && (hit || last_byte_i);
    res_o.found         = hit;
    res_o.match_address = hit ? (cfg_i.base + pos_nx -
                                 {{(wbps_pkg::AddrW - wbps_pkg::LenW){1'b0}}, cfg_i.len})
                              : '0;
  end

  always_comb begin
    fill_d = fill_q;
    pos_d  = pos_q;
    seen_d = seen_q;
    if (step_i) begin
      if (last_byte_i) begin
        fill_d = '0;
        pos_d  = '0;
        seen_d = 1'b0;
      end else begin
        fill_d = fill_nx;
        pos_d  = pos_nx;
        seen_d = seen_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      pos_q  <= pos_d;
      seen_q <= seen_d;
    end
  end

  // window contents are gated by the fill count, so no clear is needed
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      win_q <= win_nx;
    end
  end

endmodule
